@@ hdl/pofr_pkg.sv @@
// shared types and constants for the paged oled frame buffer refresher
// no dependencies; imported by pofr_store, pofr_ctrl and the top level
package pofr_pkg;

    // panel geometry
    localparam int WIDTH       = 64;
    localparam int PAGES       = 6;
    localparam int ROWS        = PAGES * 8;
    localparam int STORE_DEPTH = WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // refresh stream layout: page command, two column commands, then data
    localparam int HEADER_LEN = 3;
    localparam int POS_W      = 8;
    localparam int PAGE_W     = 3;

    localparam logic [7:0] PAGE_CMD     = 8'hB0;
    localparam logic [7:0] COL_HIGH_CMD = 8'h12;
    localparam logic [7:0] COL_LOW_CMD  = 8'h00;

    // action codes
    localparam logic [1:0] ACT_PIXEL   = 2'd0;
    localparam logic [1:0] ACT_CLEAR   = 2'd1;
    localparam logic [1:0] ACT_REFRESH = 2'd2;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // request from the controller to the frame store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

@@ hdl/pofr_store.sv @@
// frame store: one byte per column per page, single write and single read port
// read data is registered; depends on pofr_pkg
module pofr_store (
    input  logic               i_clk,
    input  pofr_pkg::t_mem_req i_req,
    output logic [7:0]         o_rd_data
);
    import pofr_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/pofr_ctrl.sv @@
// item sequencer: decodes items, runs the clearing sweep, does read-modify-write
// of store bytes, walks the refresh stream and holds the result register; uses pofr_pkg
module pofr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic [7:0]         i_pixel_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_is_data,
    output logic               o_frame_end,
    output logic               o_range_error,
    output pofr_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_rd_data
);
    import pofr_pkg::*;

    t_state r_state, n_state;

    // per-item registers
    logic [1:0]        r_act;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_mask;
    logic              r_set;
    logic              r_err;
    logic              r_is_data;
    logic              r_last;
    logic [7:0]        r_cmd;
    logic              r_clr_item;

    // refresh walk and clearing sweep
    logic [PAGE_W-1:0] r_rf_page, n_rf_page;
    logic [POS_W-1:0]  r_rf_pos, n_rf_pos;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_byte_valid;
    logic       r_is_data_o;
    logic       r_frame_end;
    logic       r_range_error;

    logic              w_accept;
    logic              w_load;
    logic              w_slot_free;
    logic              w_clr_done;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_pix_addr;
    logic [ADDR_W-1:0] w_rf_addr;
    logic              w_rf_data;
    logic              w_rf_last;
    logic [7:0]        w_rf_cmd;
    logic [7:0]        w_res_byte;
    logic [7:0]        w_wdata;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_clr_done  = (r_clr_cnt == ADDR_W'(STORE_DEPTH - 1));

    // pixel decode
    assign w_in_range = (9'(i_pixel_x) < 9'(WIDTH)) && (9'(i_pixel_y) < 9'(ROWS));
    assign w_pix_addr = ADDR_W'(ADDR_W'(i_pixel_y[7:3]) * ADDR_W'(WIDTH))
                      + ADDR_W'(i_pixel_x);

    // refresh stream position decode
    assign w_rf_data = (r_rf_pos >= POS_W'(HEADER_LEN));
    assign w_rf_addr = ADDR_W'(ADDR_W'(r_rf_page) * ADDR_W'(WIDTH))
                     + ADDR_W'(r_rf_pos - POS_W'(HEADER_LEN));

    always_comb begin
        case (r_rf_pos)
            POS_W'(0): w_rf_cmd = PAGE_CMD | 8'(r_rf_page);
            POS_W'(1): w_rf_cmd = COL_HIGH_CMD;
            default:   w_rf_cmd = COL_LOW_CMD;
        endcase
    end

    // next refresh position with page and frame wrap
    always_comb begin
        n_rf_page = r_rf_page;
        n_rf_pos  = r_rf_pos + POS_W'(1);
        w_rf_last = 1'b0;
        if (r_rf_pos == POS_W'(HEADER_LEN + WIDTH - 1)) begin
            n_rf_pos = '0;
            if (r_rf_page == PAGE_W'(PAGES - 1)) begin
                n_rf_page = '0;
                w_rf_last = 1'b1;
            end else begin
                n_rf_page = r_rf_page + PAGE_W'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_done) begin
                    n_state = r_clr_item ? ST_EXEC : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_action == ACT_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // modified byte for a pixel write
    assign w_wdata = r_set ? (i_rd_data | r_mask) : (i_rd_data & ~r_mask);

    // state outputs: handshake, memory requests, result load
    always_comb begin
        o_in_ready      = 1'b0;
        w_load          = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_addr;
        o_mem_req.wdata = w_wdata;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = (i_action == ACT_REFRESH) ? w_rf_addr : w_pix_addr;
        case (r_state)
            ST_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr_cnt;
                o_mem_req.wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_mem_req.re = i_in_valid;
            end
            ST_EXEC: begin
                w_load       = w_slot_free;
                o_mem_req.we = w_slot_free && (r_act == ACT_PIXEL) && !r_err;
            end
            default: ;
        endcase
    end

    assign n_clr_cnt = (r_state != ST_CLEAR) ? r_clr_cnt
                     : (w_clr_done ? '0 : r_clr_cnt + ADDR_W'(1));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_item  <= 1'b0;
            r_rf_page   <= '0;
            r_rf_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (w_accept) begin
                r_clr_item <= (i_action == ACT_CLEAR);
            end
            if (w_accept && (i_action == ACT_REFRESH)) begin
                r_rf_page <= n_rf_page;
                r_rf_pos  <= n_rf_pos;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act     <= i_action;
            r_addr    <= w_pix_addr;
            r_mask    <= 8'(8'd1 << i_pixel_y[2:0]);
            r_set     <= (i_pixel_value == 8'd1);
            r_err     <= !w_in_range;
            r_is_data <= w_rf_data;
            r_last    <= w_rf_last;
            r_cmd     <= w_rf_cmd;
        end
    end

    // result of the item in flight
    always_comb begin
        w_res_byte = '0;
        if (r_act == ACT_REFRESH) begin
            w_res_byte = r_is_data ? i_rd_data : r_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte    <= w_res_byte;
            r_byte_valid  <= (r_act == ACT_REFRESH);
            r_is_data_o   <= (r_act == ACT_REFRESH) && r_is_data;
            r_frame_end   <= (r_act == ACT_REFRESH) && r_last;
            r_range_error <= (r_act == ACT_PIXEL) && r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_is_data     = r_is_data_o;
    assign o_frame_end   = r_frame_end;
    assign o_range_error = r_range_error;

    // refresh walk never leaves the stream
    a_rf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rf_pos < POS_W'(HEADER_LEN + WIDTH)) && (r_rf_page < PAGE_W'(PAGES)))
        else $error("refresh position out of range");

    // store is never written while waiting for an item
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_mem_req.we)
        else $error("store write while idle");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted item not started");

    // frame end only on a data byte
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_is_data && o_byte_valid))
        else $error("frame end on a non-data result");

    // a result is loaded only when the slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

endmodule

@@ hdl/paged_oled_framebuffer_refresher.sv @@
// top level of the paged oled frame buffer refresher
// depends on pofr_pkg, pofr_store and pofr_ctrl
//
// Monochrome frame store of WIDTH columns by PAGES pages of eight rows, one byte
// per column per page, with the panel refresh stream taken one byte per item.
// Every item gives exactly one result. For pixel and refresh items the accept
// cycle issues the read of the store byte; in the execute state, once the
// result register is free, the block uses the registered read data, writes a
// pixel's modified byte back and loads the result register. A clear item runs
// a sweep over all WIDTH*PAGES store bytes (384 by default) that writes one
// store byte per cycle, then loads its all-zero result in the execute state once
// the result register is free. After reset the same sweep runs before the first
// item is accepted. A new item may be accepted while the previous result still waits.
module paged_oled_framebuffer_refresher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic [7:0] i_pixel_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_is_data,
    output logic       o_frame_end,
    output logic       o_range_error
);
    import pofr_pkg::*;

    t_mem_req   w_mem_req;
    logic [7:0] w_rd_data;

    // sequencer and result register
    pofr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_is_data     (o_is_data),
        .o_frame_end   (o_frame_end),
        .o_range_error (o_range_error),
        .o_mem_req     (w_mem_req),
        .i_rd_data     (w_rd_data)
    );

    // frame store memory
    pofr_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

endmodule

@@ sim/paged_oled_framebuffer_refresher_test.sv @@
// self-checking testbench for paged_oled_framebuffer_refresher
// depends on pofr_pkg and the rtl under hdl; keeps its own copy of the frame store
module paged_oled_framebuffer_refresher_test;
    import pofr_pkg::*;

    // spare action code, must leave everything untouched
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int STEADY_FIRST = 250;
    localparam int STEADY_LAST  = 400;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_data;
        logic       frame_end;
        logic       range_error;
    } t_result;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] value;
        logic       typed;
        t_result    res;
    } t_row;

    localparam t_result RES_NONE  = '0;
    localparam t_result RES_RANGE = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam int      ROW_COUNT = 19;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_action;
    logic [7:0] i_pixel_x;
    logic [7:0] i_pixel_y;
    logic [7:0] i_pixel_value;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_is_data;
    logic       o_frame_end;
    logic       o_range_error;

    // shadow copy of the block state
    logic [7:0]  shadow_store [STORE_DEPTH];
    int unsigned scan_page = 0;
    int unsigned scan_pos = 0;
    int unsigned frame_ends = 0;

    t_result pending_results [$];
    t_result want;
    t_row    stim_table [ROW_COUNT];
    int      error_count = 0;
    bit      calm = 1'b0;

    paged_oled_framebuffer_refresher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_is_data     (o_is_data),
        .o_frame_end   (o_frame_end),
        .o_range_error (o_range_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input int got, input int wanted);
        $display("mismatch at %0t on %s: got %0h, expected %0h", $time, field, got, wanted);
        error_count++;
    endtask

    // applies one item to the shadow state and returns the panel result it gives
    task automatic apply_panel_item(input logic [1:0] act, input logic [7:0] x,
                                    input logic [7:0] y, input logic [7:0] value,
                                    output t_result r);
        int unsigned idx;
        r = '0;
        case (act)
            ACT_PIXEL: begin
                if (x >= WIDTH || y >= ROWS) begin
                    r.range_error = 1'b1;
                end else begin
                    idx = y[7:3] * WIDTH + x;
                    shadow_store[idx][y[2:0]] = (value == 8'd1);
                end
            end
            ACT_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            end
            ACT_REFRESH: begin
                r.byte_valid = 1'b1;
                if (scan_pos == 0) begin
                    r.out_byte = PAGE_CMD | 8'(scan_page);
                end else if (scan_pos == 1) begin
                    r.out_byte = COL_HIGH_CMD;
                end else if (scan_pos == 2) begin
                    r.out_byte = COL_LOW_CMD;
                end else begin
                    r.out_byte = shadow_store[scan_page * WIDTH + scan_pos - HEADER_LEN];
                    r.is_data  = 1'b1;
                end
                // advance position, wrap page and frame
                scan_pos++;
                if (scan_pos >= HEADER_LEN + WIDTH) begin
                    scan_pos = 0;
                    scan_page++;
                    if (scan_page >= PAGES) begin
                        scan_page   = 0;
                        r.frame_end = 1'b1;
                        frame_ends++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // presents one item, waits for it to be taken, records what should come back
    task automatic offer_item(input logic [1:0] act, input logic [7:0] x,
                              input logic [7:0] y, input logic [7:0] value,
                              input logic typed, input t_result typed_res);
        t_result r;
        while (!calm && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        i_pixel_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_panel_item(act, x, y, value, r);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // result side stalls
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 30);
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result byte", o_out_byte, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_out_byte, want.out_byte);
                if (o_byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                if (o_is_data !== want.is_data)
                    report_mismatch("is_data", o_is_data, want.is_data);
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
                if (o_range_error !== want.range_error)
                    report_mismatch("range_error", o_range_error, want.range_error);
            end
        end
    end

    // stimulus
    initial begin
        int         pick;
        logic [1:0] act;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] value;

        foreach (shadow_store[i]) shadow_store[i] = 8'h00;

        // directed items: header bytes, field extremes, range errors, clear, spare code
        stim_table = '{
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'hB0, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'h12, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{ACT_PIXEL,   8'd0,   8'd0,   8'd1,   1'b1, RES_NONE},
            '{ACT_PIXEL,   8'd63,  8'd47,  8'hFF,  1'b1, RES_NONE},
            '{ACT_PIXEL,   8'd63,  8'd47,  8'd1,   1'b1, RES_NONE},
            '{ACT_PIXEL,   8'd64,  8'd0,   8'd1,   1'b1, RES_RANGE},
            '{ACT_PIXEL,   8'd0,   8'd48,  8'd1,   1'b1, RES_RANGE},
            '{ACT_PIXEL,   8'hFF,  8'hFF,  8'hFF,  1'b1, RES_RANGE},
            '{ACT_PIXEL,   8'd5,   8'd3,   8'd2,   1'b1, RES_NONE},
            '{ACT_PIXEL,   8'd1,   8'd7,   8'd1,   1'b1, RES_NONE},
            '{ACT_REFRESH, 8'hFF,  8'hFF,  8'hFF,  1'b1, '{8'h01, 1'b1, 1'b1, 1'b0, 1'b0}},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
            '{ACT_SPARE,   8'hFF,  8'hFF,  8'hFF,  1'b1, RES_NONE},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
            '{ACT_CLEAR,   8'hFF,  8'hFF,  8'hFF,  1'b1, RES_NONE},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
            '{ACT_PIXEL,   8'd4,   8'd0,   8'd1,   1'b1, RES_NONE},
            '{ACT_REFRESH, 8'd0,   8'd0,   8'd0,   1'b0, RES_NONE}
        };

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_PIXEL;
        i_pixel_x     <= 8'd0;
        i_pixel_y     <= 8'd0;
        i_pixel_value <= 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            offer_item(stim_table[i].act, stim_table[i].x, stim_table[i].y,
                       stim_table[i].value, stim_table[i].typed, stim_table[i].res);
        end

        // random items, mostly refresh steps and in-range pixels; runs past a frame end
        for (int n = 0; n < RANDOM_ITEMS || frame_ends == 0; n++) begin
            calm = (n >= STEADY_FIRST && n < STEADY_LAST);
            pick = $urandom_range(99);
            if (pick < 72)
                act = ACT_REFRESH;
            else if (pick < 96)
                act = ACT_PIXEL;
            else if (pick < 98)
                act = ACT_CLEAR;
            else
                act = ACT_SPARE;
            x = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(WIDTH - 1));
            y = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(ROWS - 1));
            pick = $urandom_range(9);
            if (pick < 5)
                value = 8'd1;
            else if (pick < 7)
                value = 8'd0;
            else
                value = 8'($urandom_range(255));
            offer_item(act, x, y, value, 1'b0, RES_NONE);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pofr_pkg.sv
hdl/pofr_store.sv
hdl/pofr_ctrl.sv
hdl/paged_oled_framebuffer_refresher.sv
sim/paged_oled_framebuffer_refresher_test.sv
